/* hw/rtl/disc_elastic_collision_macros.svh */
// Assertion helpers used by the checker file.
`ifndef DISC_ELASTIC_COLLISION_MACROS_SVH
`define DISC_ELASTIC_COLLISION_MACROS_SVH

// Same-cycle implication.
`define DEC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("disc collision check failed");

// Next-cycle implication.
`define DEC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("disc collision check failed");

`endif

/* hw/rtl/dec_pkg.sv */
package dec_pkg;

  localparam int WORD_BITS  = 32;
  localparam int SQRT_STEPS = 31;
  localparam int DIV_STEPS  = 32;
  localparam int DIV_LANES  = 4;
  localparam int REM_W      = 34;
  localparam int QUO_W      = 32;
  localparam int DVD_W      = 64;

  localparam logic [WORD_BITS-2:0] RESET_LIMIT = 31'd655360;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] vx1;
    logic signed [WORD_BITS-1:0] vy1;
    logic signed [WORD_BITS-1:0] vx2;
    logic signed [WORD_BITS-1:0] vy2;
    logic                        b1;
    logic                        b2;
    logic                        same;
    logic                        negx;
    logic                        negy;
  } side_t;

endpackage

/* hw/rtl/dec_div_pipe.sv */
module dec_div_pipe import dec_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  side_t            side_i,
  input  logic [DVD_W-1:0] dvd_i [DIV_LANES],
  input  logic [REM_W-1:0] dvs_i [DIV_LANES],
  output logic             valid_o,
  output side_t            side_o,
  output logic [QUO_W-1:0] quo_o [DIV_LANES]
);

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] low;
    logic [REM_W-1:0] dvs;
    logic [QUO_W-1:0] quo;
  } lane_t;

  logic  vld_q  [DIV_STEPS];
  side_t side_q [DIV_STEPS];
  lane_t lane_q [DIV_STEPS][DIV_LANES];

  // one restoring quotient bit per stage, all lanes in parallel
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic  vld_in;
    side_t side_in;
    lane_t lane_in [DIV_LANES];
    lane_t lane_d  [DIV_LANES];

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign side_in = side_i;
      for (genvar l = 0; l < DIV_LANES; l++) begin : g_load
        assign lane_in[l] = '{rem: REM_W'(dvd_i[l][DVD_W-1:QUO_W]),
                              low: dvd_i[l][QUO_W-1:0],
                              dvs: dvs_i[l],
                              quo: '0};
      end
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign side_in = side_q[k-1];
      assign lane_in = lane_q[k-1];
    end

    for (genvar l = 0; l < DIV_LANES; l++) begin : g_calc
      logic [REM_W-1:0] t;
      logic             ge;
      assign t  = {lane_in[l].rem[REM_W-2:0], lane_in[l].low[QUO_W-1]};
      assign ge = t >= lane_in[l].dvs;
      assign lane_d[l] = '{rem: ge ? t - lane_in[l].dvs : t,
                           low: {lane_in[l].low[QUO_W-2:0], 1'b0},
                           dvs: lane_in[l].dvs,
                           quo: {lane_in[l].quo[QUO_W-2:0], ge}};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_in;
        lane_q[k] <= lane_d;
      end
    end
  end

  assign valid_o = vld_q[DIV_STEPS-1];
  assign side_o  = side_q[DIV_STEPS-1];

  for (genvar l = 0; l < DIV_LANES; l++) begin : g_out
    assign quo_o[l] = lane_q[DIV_STEPS-1][l].quo;
  end

endmodule

/* hw/rtl/disc_elastic_collision.sv */
// Elastic bounce of two discs in signed Q16.16. One transaction enters per
// cycle and its result passes through 2 setup stages, 31 stages of
// the bit-per-stage square root that gives the centre distance, 32 stages of
// the shared four-lane divider (unit normal and mass weights), then 5 stages
// of projection, impulse and clamping. When the result is not taken the
// whole pipeline holds. Coinciding centres pass both velocities through and
// raise centres_coincide_o; a disc without its bounce flag keeps its velocity.
module disc_elastic_collision import dec_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [WORD_BITS-2:0]        cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [WORD_BITS-1:0] first_x_i,
  input  logic signed [WORD_BITS-1:0] first_y_i,
  input  logic signed [WORD_BITS-1:0] first_vx_i,
  input  logic signed [WORD_BITS-1:0] first_vy_i,
  input  logic [WORD_BITS-2:0]        first_radius_i,
  input  logic signed [WORD_BITS-1:0] second_x_i,
  input  logic signed [WORD_BITS-1:0] second_y_i,
  input  logic signed [WORD_BITS-1:0] second_vx_i,
  input  logic signed [WORD_BITS-1:0] second_vy_i,
  input  logic [WORD_BITS-2:0]        second_radius_i,
  input  logic                        first_may_bounce_i,
  input  logic                        second_may_bounce_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [WORD_BITS-1:0] new_first_vx_o,
  output logic signed [WORD_BITS-1:0] new_first_vy_o,
  output logic signed [WORD_BITS-1:0] new_second_vx_o,
  output logic signed [WORD_BITS-1:0] new_second_vy_o,
  output logic                        first_changed_o,
  output logic                        second_changed_o,
  output logic                        centres_coincide_o
);

  typedef struct packed {
    side_t       side;
    logic [29:0] ax;
    logic [29:0] ay;
    logic [15:0] r1;
    logic [15:0] r2;
  } a_t;

  typedef struct packed {
    side_t       side;
    logic [29:0] ax;
    logic [29:0] ay;
    logic [31:0] q1;
    logic [31:0] q2;
    logic [32:0] sum;
  } carry_t;

  typedef struct packed {
    carry_t      c;
    logic [61:0] v;
    logic [33:0] rem;
    logic [30:0] root;
  } sq_t;

  typedef struct packed {
    side_t                     side;
    logic signed [3:0][33:0]   p;
    logic [30:0]               nxm;
    logic [30:0]               nym;
    logic [31:0]               w1;
    logic [31:0]               w2;
  } m1_t;

  typedef struct packed {
    side_t              side;
    logic signed [35:0] rel;
    logic [30:0]        nxm;
    logic [30:0]        nym;
    logic [31:0]        w1;
    logic [31:0]        w2;
  } m2_t;

  typedef struct packed {
    side_t       side;
    logic [34:0] imp1m;
    logic [34:0] imp2m;
    logic        imp1n;
    logic        imp2n;
    logic [30:0] nxm;
    logic [30:0] nym;
  } m3_t;

  typedef struct packed {
    side_t                   side;
    logic signed [3:0][36:0] e;
  } m4_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] vx1;
    logic [WORD_BITS-1:0] vy1;
    logic [WORD_BITS-1:0] vx2;
    logic [WORD_BITS-1:0] vy2;
    logic                 c1;
    logic                 c2;
    logic                 same;
  } out_t;

  function automatic logic signed [33:0] mul_vn(logic signed [31:0] v, logic [30:0] n,
                                                 logic nneg);
    logic [31:0]        mv;
    logic [62:0]        pr;
    logic signed [33:0] r;
    mv = v[31] ? 32'(-v) : 32'(v);
    pr = mv * n;
    r  = signed'({1'b0, pr[62:30]});
    return (v[31] ^ nneg) ? -r : r;
  endfunction

  function automatic logic signed [36:0] mul_en(logic [34:0] im, logic ineg,
                                                 logic [30:0] n, logic nneg);
    logic [65:0]        pr;
    logic signed [36:0] r;
    pr = im * n;
    r  = signed'({1'b0, pr[65:30]});
    return (ineg ^ nneg) ? -r : r;
  endfunction

  function automatic logic [31:0] clamp_v(logic signed [37:0] v, logic [30:0] lim);
    logic signed [37:0] l;
    logic signed [37:0] r;
    l = signed'({7'b0, lim});
    r = v;
    if (v > l) begin
      r = l;
    end else if (v < -l) begin
      r = -l;
    end
    return r[31:0];
  endfunction

  logic [WORD_BITS-2:0] limit_q;
  logic                 en;

  logic   a_vld_q, b_vld_q, m1_vld_q, m2_vld_q, m3_vld_q, m4_vld_q, out_vld_q;
  a_t     a_d, a_q;
  carry_t b_d, b_q;
  logic [60:0] b_sq_d, b_sq_q;
  sq_t    sq_q [SQRT_STEPS];
  logic   sq_vld_q [SQRT_STEPS];
  m1_t    m1_d, m1_q;
  m2_t    m2_d, m2_q;
  m3_t    m3_d, m3_q;
  m4_t    m4_d, m4_q;
  out_t   out_d, out_q;

  logic             dv_vld;
  side_t            dv_side;
  logic [DVD_W-1:0] dv_dvd [DIV_LANES];
  logic [REM_W-1:0] dv_dvs [DIV_LANES];
  logic [QUO_W-1:0] dv_quo [DIV_LANES];

  assign en         = out_ready_i | ~out_vld_q;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= RESET_LIMIT;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // setup: centre difference scaled below 2^30, radii scaled below 2^16
  always_comb begin
    logic signed [WORD_BITS:0] dx, dy;
    logic [WORD_BITS:0]        ax, ay, mx;
    logic [1:0]                sh;
    logic [WORD_BITS-2:0]      rm;
    logic [3:0]                rsh;
    dx = {second_x_i[WORD_BITS-1], second_x_i} - {first_x_i[WORD_BITS-1], first_x_i};
    dy = {second_y_i[WORD_BITS-1], second_y_i} - {first_y_i[WORD_BITS-1], first_y_i};
    ax = dx[WORD_BITS] ? -dx : dx;
    ay = dy[WORD_BITS] ? -dy : dy;
    mx = (ax > ay) ? ax : ay;
    if (mx[32]) begin
      sh = 2'd3;
    end else if (mx[31]) begin
      sh = 2'd2;
    end else if (mx[30]) begin
      sh = 2'd1;
    end else begin
      sh = 2'd0;
    end
    rm  = (first_radius_i > second_radius_i) ? first_radius_i : second_radius_i;
    rsh = 4'd0;
    for (int i = 0; i < 15; i++) begin
      if (|(rm >> (16 + i))) begin
        rsh = 4'(i + 1);
      end
    end
    a_d.ax        = 30'(ax >> sh);
    a_d.ay        = 30'(ay >> sh);
    a_d.r1        = 16'(first_radius_i >> rsh);
    a_d.r2        = 16'(second_radius_i >> rsh);
    a_d.side.vx1  = first_vx_i;
    a_d.side.vy1  = first_vy_i;
    a_d.side.vx2  = second_vx_i;
    a_d.side.vy2  = second_vy_i;
    a_d.side.b1   = first_may_bounce_i;
    a_d.side.b2   = second_may_bounce_i;
    a_d.side.same = (dx == '0) && (dy == '0);
    a_d.side.negx = dx[WORD_BITS];
    a_d.side.negy = dy[WORD_BITS];
  end

  // squares for the distance and the masses
  always_comb begin
    logic [59:0] axx, ayy;
    logic [31:0] q1, q2;
    axx      = a_q.ax * a_q.ax;
    ayy      = a_q.ay * a_q.ay;
    q1       = a_q.r1 * a_q.r1;
    q2       = a_q.r2 * a_q.r2;
    b_sq_d   = {1'b0, axx} + {1'b0, ayy};
    b_d.side = a_q.side;
    b_d.ax   = a_q.ax;
    b_d.ay   = a_q.ay;
    b_d.q1   = q1;
    b_d.q2   = q2;
    b_d.sum  = {1'b0, q1} + {1'b0, q2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      m1_vld_q  <= 1'b0;
      m2_vld_q  <= 1'b0;
      m3_vld_q  <= 1'b0;
      m4_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q   <= in_valid_i;
      b_vld_q   <= a_vld_q;
      m1_vld_q  <= dv_vld;
      m2_vld_q  <= m1_vld_q;
      m3_vld_q  <= m2_vld_q;
      m4_vld_q  <= m3_vld_q;
      out_vld_q <= m4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q    <= a_d;
      b_q    <= b_d;
      b_sq_q <= b_sq_d;
      m1_q   <= m1_d;
      m2_q   <= m2_d;
      m3_q   <= m3_d;
      m4_q   <= m4_d;
      out_q  <= out_d;
    end
  end

  // integer square root, one result bit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic        vld_in;
    sq_t         sq_in, sq_d;
    logic [33:0] rem_t, trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign vld_in = b_vld_q;
      assign sq_in  = '{c: b_q, v: {1'b0, b_sq_q}, rem: '0, root: '0};
    end else begin : g_next
      assign vld_in = sq_vld_q[k-1];
      assign sq_in  = sq_q[k-1];
    end

    assign rem_t = {sq_in.rem[31:0], sq_in.v[61:60]};
    assign trial = {1'b0, sq_in.root, 2'b01};
    assign ge    = rem_t >= trial;
    assign sq_d  = '{c: sq_in.c, v: {sq_in.v[59:0], 2'b00},
                     rem: ge ? rem_t - trial : rem_t,
                     root: {sq_in.root[29:0], ge}};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[k] <= 1'b0;
      end else if (en) begin
        sq_vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[k] <= sq_d;
      end
    end
  end

  // lanes: nx, ny, w1, w2; zero total mass gives weight 1.0 via 2^30 / 1
  always_comb begin
    carry_t c;
    c         = sq_q[SQRT_STEPS-1].c;
    dv_dvd[0] = {4'b0, c.ax, 30'b0};
    dv_dvd[1] = {4'b0, c.ay, 30'b0};
    dv_dvs[0] = {3'b0, sq_q[SQRT_STEPS-1].root};
    dv_dvs[1] = {3'b0, sq_q[SQRT_STEPS-1].root};
    if (c.sum == '0) begin
      dv_dvd[2] = DVD_W'(64'd1 << 30);
      dv_dvd[3] = DVD_W'(64'd1 << 30);
      dv_dvs[2] = REM_W'(1);
      dv_dvs[3] = REM_W'(1);
    end else begin
      dv_dvd[2] = {1'b0, c.q2, 31'b0};
      dv_dvd[3] = {1'b0, c.q1, 31'b0};
      dv_dvs[2] = {1'b0, c.sum};
      dv_dvs[3] = {1'b0, c.sum};
    end
  end

  dec_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_vld_q[SQRT_STEPS-1]),
    .side_i  (sq_q[SQRT_STEPS-1].c.side),
    .dvd_i   (dv_dvd),
    .dvs_i   (dv_dvs),
    .valid_o (dv_vld),
    .side_o  (dv_side),
    .quo_o   (dv_quo)
  );

  // projections onto the normal
  always_comb begin
    m1_d.side = dv_side;
    m1_d.nxm  = dv_quo[0][30:0];
    m1_d.nym  = dv_quo[1][30:0];
    m1_d.w1   = dv_quo[2];
    m1_d.w2   = dv_quo[3];
    m1_d.p[0] = mul_vn(dv_side.vx1, dv_quo[0][30:0], dv_side.negx);
    m1_d.p[1] = mul_vn(dv_side.vy1, dv_quo[1][30:0], dv_side.negy);
    m1_d.p[2] = mul_vn(dv_side.vx2, dv_quo[0][30:0], dv_side.negx);
    m1_d.p[3] = mul_vn(dv_side.vy2, dv_quo[1][30:0], dv_side.negy);
  end

  always_comb begin
    logic signed [35:0] vn1, vn2;
    vn1       = 36'(signed'(m1_q.p[0])) + 36'(signed'(m1_q.p[1]));
    vn2       = 36'(signed'(m1_q.p[2])) + 36'(signed'(m1_q.p[3]));
    m2_d.side = m1_q.side;
    m2_d.rel  = vn2 - vn1;
    m2_d.nxm  = m1_q.nxm;
    m2_d.nym  = m1_q.nym;
    m2_d.w1   = m1_q.w1;
    m2_d.w2   = m1_q.w2;
  end

  // impulses
  always_comb begin
    logic [33:0] relm;
    logic [65:0] p1, p2;
    relm       = m2_q.rel[35] ? 34'(-m2_q.rel) : 34'(m2_q.rel);
    p1         = relm * m2_q.w1;
    p2         = relm * m2_q.w2;
    m3_d.side  = m2_q.side;
    m3_d.imp1m = p1[64:30];
    m3_d.imp2m = p2[64:30];
    m3_d.imp1n = m2_q.rel[35];
    m3_d.imp2n = ~m2_q.rel[35] && (m2_q.rel != '0);
    m3_d.nxm   = m2_q.nxm;
    m3_d.nym   = m2_q.nym;
  end

  always_comb begin
    m4_d.side = m3_q.side;
    m4_d.e[0] = mul_en(m3_q.imp1m, m3_q.imp1n, m3_q.nxm, m3_q.side.negx);
    m4_d.e[1] = mul_en(m3_q.imp1m, m3_q.imp1n, m3_q.nym, m3_q.side.negy);
    m4_d.e[2] = mul_en(m3_q.imp2m, m3_q.imp2n, m3_q.nxm, m3_q.side.negx);
    m4_d.e[3] = mul_en(m3_q.imp2m, m3_q.imp2n, m3_q.nym, m3_q.side.negy);
  end

  // apply, clamp, select
  always_comb begin
    side_t s;
    logic  c1, c2;
    s          = m4_q.side;
    c1         = s.b1 & ~s.same;
    c2         = s.b2 & ~s.same;
    out_d.c1   = c1;
    out_d.c2   = c2;
    out_d.same = s.same;
    out_d.vx1  = c1 ? clamp_v(38'(s.vx1) + 38'(signed'(m4_q.e[0])), limit_q) : s.vx1;
    out_d.vy1  = c1 ? clamp_v(38'(s.vy1) + 38'(signed'(m4_q.e[1])), limit_q) : s.vy1;
    out_d.vx2  = c2 ? clamp_v(38'(s.vx2) + 38'(signed'(m4_q.e[2])), limit_q) : s.vx2;
    out_d.vy2  = c2 ? clamp_v(38'(s.vy2) + 38'(signed'(m4_q.e[3])), limit_q) : s.vy2;
  end

  assign out_valid_o        = out_vld_q;
  assign new_first_vx_o     = out_q.vx1;
  assign new_first_vy_o     = out_q.vy1;
  assign new_second_vx_o    = out_q.vx2;
  assign new_second_vy_o    = out_q.vy2;
  assign first_changed_o    = out_q.c1;
  assign second_changed_o   = out_q.c2;
  assign centres_coincide_o = out_q.same;

endmodule

/* hw/rtl/dec_checker.sv */
`include "disc_elastic_collision_macros.svh"

module dec_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] new_first_vx_o,
  input logic [31:0] new_second_vy_o,
  input logic        first_changed_o,
  input logic        second_changed_o,
  input logic        centres_coincide_o
);

  `DEC_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `DEC_ASSERT_NXT(a_out_stable, out_valid_o && !out_ready_i, $stable(new_first_vx_o) && $stable(new_second_vy_o) && $stable(first_changed_o))
  `DEC_ASSERT_IMP(a_same_unchanged, out_valid_o && centres_coincide_o, !first_changed_o && !second_changed_o)
  `DEC_ASSERT_IMP(a_empty_ready, !out_valid_o, in_ready_o)

endmodule

bind disc_elastic_collision dec_checker u_dec_checker (.*);

/* tb/tb.sv */
module tb;
  import dec_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NORM = 30;
  localparam int PIPE_DEPTH = 70;
  localparam longint MAX_CYCLES = 2000000;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [WORD_BITS-2:0] ulen_t;

  typedef struct {
    word_t x1, y1, vx1, vy1;
    ulen_t r1;
    word_t x2, y2, vx2, vy2;
    ulen_t r2;
    logic b1, b2;
  } pair_t;

  typedef struct {
    word_t v1x, v1y, v2x, v2y;
    logic c1, c2, same;
  } bounce_t;

  typedef struct {
    pair_t p;
    logic has_exp;
    bounce_t e;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  ulen_t cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  word_t first_x_i = '0, first_y_i = '0, first_vx_i = '0, first_vy_i = '0;
  ulen_t first_radius_i = '0;
  word_t second_x_i = '0, second_y_i = '0, second_vx_i = '0, second_vy_i = '0;
  ulen_t second_radius_i = '0;
  logic first_may_bounce_i = 1'b0, second_may_bounce_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  word_t new_first_vx_o, new_first_vy_o, new_second_vx_o, new_second_vy_o;
  logic first_changed_o, second_changed_o, centres_coincide_o;

  always #2 clk_i = ~clk_i;

  disc_elastic_collision uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .first_x_i(first_x_i), .first_y_i(first_y_i),
    .first_vx_i(first_vx_i), .first_vy_i(first_vy_i),
    .first_radius_i(first_radius_i),
    .second_x_i(second_x_i), .second_y_i(second_y_i),
    .second_vx_i(second_vx_i), .second_vy_i(second_vy_i),
    .second_radius_i(second_radius_i),
    .first_may_bounce_i(first_may_bounce_i), .second_may_bounce_i(second_may_bounce_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .new_first_vx_o(new_first_vx_o), .new_first_vy_o(new_first_vy_o),
    .new_second_vx_o(new_second_vx_o), .new_second_vy_o(new_second_vy_o),
    .first_changed_o(first_changed_o), .second_changed_o(second_changed_o),
    .centres_coincide_o(centres_coincide_o)
  );

  ulen_t speed_cap = RESET_LIMIT;
  bounce_t bounce_q[$];
  int errors = 0;
  int checked = 0;
  int coincide_seen = 0;
  int send_idle = 20;
  int recv_idle = 86;
  logic hold_recv = 1'b0;
  longint cycles = 0;

  // capped (a*b) >> 30 on magnitudes; 128-bit product
  function automatic longint qmul(longint a, longint b);
    logic [127:0] prod;
    logic [63:0] ua, ub, r;
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    prod = {64'd0, ua} * {64'd0, ub};
    if (prod[127:92] != 0) r = 64'd1 << 62;
    else r = prod[91:30];
    if (r > (64'd1 << 62)) r = 64'd1 << 62;
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clip(longint v);
    longint lim;
    lim = longint'(speed_cap);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic logic [63:0] sqrt64(logic [63:0] v);
    logic [63:0] res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  function automatic bounce_t predict_bounce(pair_t p);
    bounce_t o;
    longint dx, dy, nx, ny, rel, imp1, imp2;
    logic [63:0] ax, ay, m, n, q1, q2, tot, w1, w2, rr1, rr2;
    int s;
    o.v1x = p.vx1; o.v1y = p.vy1; o.v2x = p.vx2; o.v2y = p.vy2;
    o.c1 = 0; o.c2 = 0; o.same = 0;
    dx = longint'(p.x2) - longint'(p.x1);
    dy = longint'(p.y2) - longint'(p.y1);
    if (dx == 0 && dy == 0) begin
      o.same = 1;
      return o;
    end
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    m = ax > ay ? ax : ay;
    s = 0;
    while ((m >> s) >= (64'd1 << NORM)) s++;
    ax >>= s; ay >>= s;
    n = sqrt64(ax * ax + ay * ay);
    nx = longint'((ax << NORM) / n); if (dx < 0) nx = -nx;
    ny = longint'((ay << NORM) / n); if (dy < 0) ny = -ny;
    rel = (qmul(p.vx2, nx) + qmul(p.vy2, ny)) - (qmul(p.vx1, nx) + qmul(p.vy1, ny));
    rr1 = p.r1; rr2 = p.r2;
    m = rr1 > rr2 ? rr1 : rr2;
    s = 0;
    while ((m >> s) >= (64'd1 << 16)) s++;
    q1 = (rr1 >> s) * (rr1 >> s);
    q2 = (rr2 >> s) * (rr2 >> s);
    tot = q1 + q2;
    if (tot == 0) begin
      w1 = 64'd1 << NORM; w2 = w1;
    end else begin
      w1 = (q2 << 31) / tot; w2 = (q1 << 31) / tot;
    end
    imp1 = qmul(rel, longint'(w1));
    imp2 = qmul(-rel, longint'(w2));
    if (p.b1) begin
      o.v1x = word_t'(clip(longint'(p.vx1) + qmul(imp1, nx)));
      o.v1y = word_t'(clip(longint'(p.vy1) + qmul(imp1, ny)));
      o.c1 = 1;
    end
    if (p.b2) begin
      o.v2x = word_t'(clip(longint'(p.vx2) + qmul(imp2, nx)));
      o.v2y = word_t'(clip(longint'(p.vy2) + qmul(imp2, ny)));
      o.c2 = 1;
    end
    return o;
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 3))
      0: return word_t'($urandom);
      1: return word_t'($signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000);
      2: return word_t'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
      default: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    endcase
  endfunction

  function automatic ulen_t rand_radius();
    case ($urandom_range(0, 2))
      0: return ulen_t'($urandom);
      1: return ulen_t'($urandom_range(0, 32'h000a_0000));
      default: return $urandom_range(0, 3) == 0 ? '0 : ulen_t'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    p.x1 = rand_word(); p.y1 = rand_word();
    p.vx1 = rand_word(); p.vy1 = rand_word();
    p.r1 = rand_radius(); p.r2 = rand_radius();
    p.vx2 = rand_word(); p.vy2 = rand_word();
    if ($urandom_range(0, 15) == 0) begin
      p.x2 = p.x1; p.y2 = p.y1;
    end else if ($urandom_range(0, 1)) begin
      p.x2 = p.x1 + word_t'($signed($urandom_range(0, 32'h0014_0000)) - 32'sh000a_0000);
      p.y2 = p.y1 + word_t'($signed($urandom_range(0, 32'h0014_0000)) - 32'sh000a_0000);
    end else begin
      p.x2 = rand_word(); p.y2 = rand_word();
    end
    p.b1 = $urandom_range(0, 3) != 0;
    p.b2 = $urandom_range(0, 3) != 0;
    return p;
  endfunction

  // valid stays up between back-to-back transactions; it drops only while idling
  task automatic send_pair(pair_t p, bounce_t e);
    while (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    first_x_i <= p.x1; first_y_i <= p.y1; first_vx_i <= p.vx1; first_vy_i <= p.vy1;
    first_radius_i <= p.r1;
    second_x_i <= p.x2; second_y_i <= p.y2; second_vx_i <= p.vx2; second_vy_i <= p.vy2;
    second_radius_i <= p.r2;
    first_may_bounce_i <= p.b1; second_may_bounce_i <= p.b2;
    bounce_q = {bounce_q, e};
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_random(int count);
    pair_t p;
    repeat (count) begin
      p = rand_pair();
      send_pair(p, predict_bounce(p));
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (bounce_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 10) @(posedge clk_i);
  endtask

  task automatic set_limit(ulen_t v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    speed_cap = v;
  endtask

  always @(posedge clk_i) begin
    if (hold_recv) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    bounce_t exp_b;
    if (out_valid_o && out_ready_i) begin
      if (bounce_q.size() == 0) begin
        $display("%0t: result with nothing pending", $time);
        errors++;
      end else begin
        exp_b = bounce_q.pop_front();
        checked++;
        if (centres_coincide_o) coincide_seen++;
        if (new_first_vx_o !== exp_b.v1x || new_first_vy_o !== exp_b.v1y ||
            new_second_vx_o !== exp_b.v2x || new_second_vy_o !== exp_b.v2y ||
            first_changed_o !== exp_b.c1 || second_changed_o !== exp_b.c2 ||
            centres_coincide_o !== exp_b.same) begin
          $display("%0t: mismatch exp v1=(%0d,%0d) v2=(%0d,%0d) c=%b%b%b", $time,
                   exp_b.v1x, exp_b.v1y, exp_b.v2x, exp_b.v2y, exp_b.c1, exp_b.c2,
                   exp_b.same);
          $display("%0t:          act v1=(%0d,%0d) v2=(%0d,%0d) c=%b%b%b", $time,
                   new_first_vx_o, new_first_vy_o, new_second_vx_o, new_second_vy_o,
                   first_changed_o, second_changed_o, centres_coincide_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic pair_t mk(word_t x1, word_t y1, word_t vx1, word_t vy1, ulen_t r1,
                               word_t x2, word_t y2, word_t vx2, word_t vy2, ulen_t r2,
                               logic b1, logic b2);
    pair_t p;
    p.x1 = x1; p.y1 = y1; p.vx1 = vx1; p.vy1 = vy1; p.r1 = r1;
    p.x2 = x2; p.y2 = y2; p.vx2 = vx2; p.vy2 = vy2; p.r2 = r2;
    p.b1 = b1; p.b2 = b2;
    return p;
  endfunction

  function automatic bounce_t bx(word_t a, word_t b, word_t c, word_t d,
                                 logic c1, logic c2, logic s);
    bounce_t e;
    e.v1x = a; e.v1y = b; e.v2x = c; e.v2y = d; e.c1 = c1; e.c2 = c2; e.same = s;
    return e;
  endfunction

  localparam word_t ONE = 32'sh0001_0000;
  localparam word_t WMAX = 32'sh7fff_ffff;
  localparam word_t WMIN = 32'sh8000_0000;
  localparam ulen_t RMAX = 31'h7fff_ffff;

  initial begin
    row_t rows[$];
    row_t r;
    bounce_t e;
    int hold_n;

    // coinciding centres: pass through, even beyond the limit
    r.p = mk(ONE, ONE, WMAX, WMIN, ONE, ONE, ONE, -ONE, ONE, ONE, 1, 1);
    r.has_exp = 1; r.e = bx(WMAX, WMIN, -ONE, ONE, 0, 0, 1); rows = {rows, r};
    r.p = mk(WMIN, WMAX, 5, -5, RMAX, WMIN, WMAX, 7, 0, 0, 0, 1);
    r.has_exp = 1; r.e = bx(5, -5, 7, 0, 0, 0, 1); rows = {rows, r};
    // neither may bounce: unchanged and unclamped
    r.p = mk(0, 0, WMAX, WMAX, ONE, ONE, 0, WMIN, WMIN, ONE, 0, 0);
    r.has_exp = 1; r.e = bx(WMAX, WMAX, WMIN, WMIN, 0, 0, 0); rows = {rows, r};
    // head-on, equal masses: velocities swap
    r.p = mk(0, 0, ONE, 0, ONE, 2 * ONE, 0, -ONE, 0, ONE, 1, 1);
    r.has_exp = 1; r.e = bx(-ONE, 0, ONE, 0, 1, 1, 0); rows = {rows, r};
    r.p = mk(0, 0, 0, ONE, 0, 0, ONE, 0, -ONE, 0, 1, 1);
    r.has_exp = 1; r.e = bx(0, -ONE, 0, ONE, 1, 1, 0); rows = {rows, r};
    // extremes, predicted
    r.has_exp = 0;
    r.p = mk(WMIN, WMIN, WMAX, WMIN, RMAX, WMAX, WMAX, WMIN, WMAX, RMAX, 1, 1);
    rows = {rows, r};
    r.p = mk(WMAX, WMIN, WMIN, WMIN, RMAX, WMIN, WMAX, WMAX, WMAX, 0, 1, 1);
    rows = {rows, r};
    r.p = mk(0, 0, WMIN, WMAX, 0, 1, 0, WMAX, WMIN, RMAX, 1, 0);
    rows = {rows, r};
    r.p = mk(0, 0, 3 * ONE, -ONE, 2 * ONE, ONE, ONE, 0, 0, ONE, 0, 1);
    rows = {rows, r};
    r.p = mk(-1, -1, 20 * ONE, 20 * ONE, 1, 0, 0, -20 * ONE, 0, 3, 1, 1);
    rows = {rows, r};
    r.p = mk(100, -7, 0, 0, 1, -100, 7, 0, 0, 1, 1, 1);
    rows = {rows, r};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      e = rows[i].has_exp ? rows[i].e : predict_bounce(rows[i].p);
      send_pair(rows[i].p, e);
    end
    drain();

    // receiver held off while sender keeps offering
    fork
      begin
        hold_recv = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_recv = 1'b0;
      end
      send_random(200);
    join
    drain();

    set_limit('0);
    send_random(150);
    drain();
    set_limit(RMAX);
    send_random(150);
    drain();

    send_idle = 86; recv_idle = 20;
    set_limit(ulen_t'($urandom_range(1, 32'h0100_0000)));
    send_random(300);
    // sender pauses until all results are in
    in_valid_i <= 1'b0;
    while (bounce_q.size() != 0) @(posedge clk_i);
    send_random(100);
    drain();

    send_idle = 0; recv_idle = 0;
    set_limit(RESET_LIMIT);
    send_random(550);
    drain();

    $display("%0d collisions checked, %0d with coinciding centres, five speed limits",
             checked, coincide_seen);
    $display("random pairs under backpressure, idle mixes and a long output stall");
    if (errors == 0 && bounce_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d errors, %0d results missing", errors, bounce_q.size());
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

/* disc_elastic_collision.f */
+incdir+hw/rtl
hw/rtl/dec_pkg.sv
hw/rtl/dec_div_pipe.sv
hw/rtl/disc_elastic_collision.sv
hw/rtl/dec_checker.sv
tb/tb.sv
